// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the substring match finder RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The property must hold at every clock edge while out of reset.
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The condition must never be seen while out of reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_HOLDS(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

// ===== rtl/smf_pkg.sv =====
// Package for the substring match finder: widths, CSR indexes, result
// struct and the ASCII case fold. No dependencies.
package smf_pkg;

   localparam int PATTERN_MAX_DEFAULT   = 16;
   localparam int POSITION_BITS_DEFAULT = 32;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 2;
   localparam int LEN_W      = 5;
   localparam int OFFSET_W   = 32;
   localparam int BYTE_W     = 8;

   localparam logic [OFFSET_W-1:0] COUNT_MAX = '1;

   localparam logic [BYTE_W-1:0] ASCII_LOWER_A = 8'h61;
   localparam logic [BYTE_W-1:0] ASCII_LOWER_Z = 8'h7A;
   localparam logic [BYTE_W-1:0] ASCII_CASE_GAP = 8'h20;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_PATTERN_LOW  = 2'd0,
      CSR_PATTERN_HIGH = 2'd1,
      CSR_PATTERN_LEN  = 2'd2,
      CSR_CASE_EXACT   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                is_match;
      logic [OFFSET_W-1:0] match_start;
      logic [OFFSET_W-1:0] match_end;
      logic [OFFSET_W-1:0] match_count;
      logic                end_of_text;
   } result_type;

   // Fold a..z to A..Z unless the compare is exact.
   function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                   input logic exact);
      logic [BYTE_W-1:0] r;
      r = b;
      if (!exact && b >= ASCII_LOWER_A && b <= ASCII_LOWER_Z) begin
         r = b - ASCII_CASE_GAP;
      end
      return r;
   endfunction

endpackage

// ===== rtl/substring_match_finder.sv =====
// Substring match finder top level: window, compare, result register and skid.
// Depends on smf_pkg and assert_macros.svh.
// A result is registered in the result reg, or in the skid slot while rsp_* stalls, when
// its byte is accepted on req_*. Throughput: one byte per cycle while req_tready is high;
// the PATTERN_MAX-way window compare and the offset and count updates sit in one stage before the result reg.
// Reset (synchronous, active high) clears window, position, count, pattern
// registers (length 1, exact compare) and both result slots.
`include "assert_macros.svh"

module substring_match_finder
   import smf_pkg::*;
#(
   parameter int PATTERN_MAX   = PATTERN_MAX_DEFAULT,   // 1 .. 16
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT  // 8 .. 64
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,    // [7:0] text_byte
   input  logic                  req_tlast,    // last_byte

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [95:0]           rsp_tdata,    // [31:0] match_start, [63:32] match_end,
                                               // [95:64] match_count
   output logic                  rsp_tuser,    // is_match
   output logic                  rsp_tlast,    // end_of_text

   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Window index width; the window is rounded up to a power of two so that
   // every index the length arithmetic can form lands on a real entry.
   localparam int IDX_W     = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int WIN_DEPTH = 2 ** IDX_W;
   localparam int SEEN_W    = $clog2(PATTERN_MAX + 1);

   localparam logic [POSITION_BITS-1:0] POS_TOP = '1;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [CSR_DATA_W-1:0] pattern_low_ff;
   logic [CSR_DATA_W-1:0] pattern_high_ff;
   logic [LEN_W-1:0]      pattern_len_ff;
   logic                  case_exact_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         pattern_len_ff  <= LEN_W'(1);
         case_exact_ff   <= 1'b1;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_PATTERN_LOW:  pattern_low_ff  <= csr_wdata;
            CSR_PATTERN_HIGH: pattern_high_ff <= csr_wdata;
            CSR_PATTERN_LEN:  pattern_len_ff  <= csr_wdata[LEN_W-1:0];
            CSR_CASE_EXACT:   case_exact_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Search state
   // ---------------------------------------------------------------------
   logic [BYTE_W-1:0]        win_ff [WIN_DEPTH];   // newest byte in entry 0
   logic [BYTE_W-1:0]        win_in [WIN_DEPTH];
   logic [SEEN_W-1:0]        seen_ff, seen_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_W-1:0]      count_ff, count_in;

   logic                     req_accept;
   logic [LEN_W-1:0]         act_len;
   logic [SEEN_W-1:0]        seen_next;
   logic [BYTE_W-1:0]        shifted [WIN_DEPTH];
   logic [2*CSR_DATA_W-1:0]  pat_all;
   logic                     bytes_equal;
   logic                     hit;
   logic [POSITION_BITS-1:0] pos_next;
   logic [POSITION_BITS-1:0] start_pos;
   logic [OFFSET_W-1:0]      count_next;
   logic [63:0]              start_wide, end_wide;
   result_type               res_new;
   logic                     res_valid;

   assign req_accept = req_tvalid & req_tready;

   // Length above PATTERN_MAX saturates; zero never matches.
   assign act_len = (pattern_len_ff > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                           : pattern_len_ff;

   assign seen_next = (seen_ff < SEEN_W'(PATTERN_MAX)) ? seen_ff + SEEN_W'(1) : seen_ff;

   always_comb begin
      shifted[0] = req_tdata;
      for (int j = 1; j < WIN_DEPTH; j++) begin
         shifted[j] = win_ff[j-1];
      end
   end

   assign pat_all = {pattern_high_ff, pattern_low_ff};

   // Pattern byte i lines up with window entry len-1-i; one byte mux per lane.
   always_comb begin
      logic [LEN_W-1:0] k_sel;
      bytes_equal = 1'b1;
      k_sel       = '0;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         k_sel = act_len - LEN_W'(i + 1);
         if (LEN_W'(i) < act_len &&
             fold_byte(pat_all[i*BYTE_W +: BYTE_W], case_exact_ff) !=
             fold_byte(shifted[k_sel[IDX_W-1:0]], case_exact_ff)) begin
            bytes_equal = 1'b0;
         end
      end
   end

   assign hit = (act_len != '0) && (LEN_W'(seen_next) >= act_len) && bytes_equal;

   // Position stops at its top; match end equals the next position.
   assign pos_next   = (pos_ff == POS_TOP) ? POS_TOP : pos_ff + POSITION_BITS'(1);
   assign start_pos  = pos_next - POSITION_BITS'(act_len);
   assign count_next = (hit && count_ff != COUNT_MAX) ? count_ff + OFFSET_W'(1) : count_ff;

   assign start_wide = 64'(start_pos);
   assign end_wide   = 64'(pos_next);

   always_comb begin
      res_new.is_match    = hit;
      res_new.match_start = hit ? start_wide[OFFSET_W-1:0] : '0;
      res_new.match_end   = hit ? end_wide[OFFSET_W-1:0]   : '0;
      res_new.match_count = count_next;
      res_new.end_of_text = req_tlast;
   end

   assign res_valid = req_accept & (hit | req_tlast);

   // Next state: the final byte of a text restarts all search state (window, fill, position, count).
   always_comb begin
      for (int j = 0; j < WIN_DEPTH; j++) begin
         win_in[j] = req_tlast ? '0 : shifted[j];
      end
      seen_in  = req_tlast ? '0 : seen_next;
      pos_in   = req_tlast ? '0 : pos_next;
      count_in = req_tlast ? '0 : count_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < WIN_DEPTH; j++) begin
            win_ff[j] <= '0;
         end
         seen_ff  <= '0;
         pos_ff   <= '0;
         count_ff <= '0;
      end else if (req_accept) begin
         win_ff   <= win_in;
         seen_ff  <= seen_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result register plus one skid slot: input stalls only when both hold
   // an item.
   // ---------------------------------------------------------------------
   result_type out_ff, skid_ff;
   logic       out_valid_ff, skid_valid_ff;

   assign req_tready = ~skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_tready) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (res_valid) begin
         if (!out_valid_ff || rsp_tready) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_tready) begin
            out_ff <= skid_ff;
         end
      end else if (res_valid) begin
         if (!out_valid_ff || rsp_tready) begin
            out_ff <= res_new;
         end else begin
            skid_ff <= res_new;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.match_count, out_ff.match_end, out_ff.match_start};
   assign rsp_tuser  = out_ff.is_match;
   assign rsp_tlast  = out_ff.end_of_text;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   `ASSERT_HOLDS(a_skid_behind_out, clock, reset, skid_valid_ff |-> out_valid_ff, "skid item without result item")
   `ASSERT_NEVER(a_seen_bound, clock, reset, seen_ff > SEEN_W'(PATTERN_MAX), "window fill beyond pattern max")
   `ASSERT_HOLDS(a_restart, clock, reset, (req_accept && req_tlast) |=> (pos_ff == '0 && count_ff == '0 && seen_ff == '0), "text did not restart after final byte")
   `ASSERT_HOLDS(a_pos_step, clock, reset, (req_accept && !req_tlast) |=> (pos_ff == (($past(pos_ff) == POS_TOP) ? POS_TOP : $past(pos_ff) + POSITION_BITS'(1))), "position did not advance by one item")
   `ASSERT_HOLDS(a_stall_hold, clock, reset, (out_valid_ff && !rsp_tready) |=> (out_valid_ff && $stable(out_ff)), "stalled result item changed")

endmodule
